[hw/rtl/dodq_pkg.sv]
// Shared constants, codes and types of the drop-oldest descriptor queue.
`default_nettype none

package dodq_pkg;

   localparam int SLOTS_DEFAULT = 4;

   localparam int FUNC_W     = 2;
   localparam int LEN_IN_W   = 24;
   localparam int LEN_W      = 21;
   localparam int GAIN_W     = 8;
   localparam int FSIZE_W    = 5;
   localparam int QUAL_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 2;
   localparam int DEPTH_W    = 3;
   localparam int BYTES_W    = 23;
   localparam int TOTAL_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(400 * 1024);

   localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic                payload_present;
      logic [LEN_IN_W-1:0] payload_length;
      logic [GAIN_W-1:0]   sensor_gain;
      logic                infrared_on;
      logic [FSIZE_W-1:0]  frame_size_code;
      logic [QUAL_W-1:0]   jpeg_quality;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [LEN_W-1:0]      entry_length;
      logic [GAIN_W-1:0]     entry_gain;
      logic                  entry_infrared;
      logic [FSIZE_W-1:0]    entry_frame_size;
      logic [QUAL_W-1:0]     entry_quality;
      logic [DEPTH_W-1:0]    depth;
      logic [BYTES_W-1:0]    bytes_held;
      logic [TOTAL_W-1:0]    dropped_total;
      logic [TOTAL_W-1:0]    drained_total;
   } rsp_word_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [GAIN_W-1:0]  gain;
      logic               infrared;
      logic [FSIZE_W-1:0] frame_size;
      logic [QUAL_W-1:0]  quality;
   } desc_type;

   typedef struct packed {
      logic load;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

[hw/rtl/dodq_chan_if.sv]
// Valid/ready channel interface carrying one word of a given payload type.
`default_nettype none

interface dodq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/drop_oldest_descriptor_queue.sv]
// Top level of the drop-oldest descriptor queue.
// Each request word (enqueue, peek oldest, release oldest) gives exactly one result word.
// A word is taken while the controller is idle, and the descriptor at the tail is read
// from the store into a register as it is taken; the result register is loaded from it once
// the result side is free, and no new word is taken before that load. The result
// register frees the request side: a new word is taken while the previous result waits,
// and a result is held back only while the one before it has not been taken. The slot
// capacity register sits at byte address 0 of the configuration port; no clearing pass
// follows reset.
`default_nettype none

module drop_oldest_descriptor_queue import dodq_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dodq_chan_if.sink                  req_chan,
   dodq_chan_if.source                rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   ctrl_cmd_type     cmd;
   ctrl_stat_type    stat;
   logic [LEN_W-1:0] capacity;
   logic             req_ready;
   logic             rsp_valid;
   rsp_word_type     rsp_word;

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_word;

   dodq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   dodq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dodq_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_chan.payload),
      .capacity  (capacity),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

[hw/rtl/dodq_csr.sv]
// APB-style configuration register holding the slot capacity.
`default_nettype none

module dodq_csr import dodq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      logic [LEN_W-1:0]      capacity
);

   logic [LEN_W-1:0] capacity_ff;
   logic [LEN_W-1:0] capacity_in;
   logic             hit;

   assign hit        = (csr_paddr[2] == CSR_IDX_CAPACITY);
   assign csr_pready = 1'b1;
   assign capacity   = capacity_ff;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         capacity_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dodq_ctrl.sv]
// Controller sequencing capture, store read and commit of each word.
`default_nettype none

module dodq_ctrl import dodq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire ctrl_stat_type stat,
   output      ctrl_cmd_type  cmd
);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_COMMIT = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.commit = (state_ff == S_COMMIT) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/dodq_datapath.sv]
// Datapath: ring pointers, counters, descriptor store and result register.
`default_nettype none

module dodq_datapath import dodq_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output      ctrl_stat_type stat,
   input  wire req_word_type  req_word,
   input  wire logic [LEN_W-1:0] capacity,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      rsp_word_type  rsp_word
);

   localparam int PTR_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOTS);

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [TOTAL_W-1:0] drops_ff, drops_in;
   logic [TOTAL_W-1:0] drains_ff, drains_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;
   req_word_type       req_ff;
   desc_type           rd_ff;
   desc_type           store [SLOTS];

   logic               wr_en;
   desc_type           wr_desc;
   logic [STATUS_W-1:0] status;
   logic [PTR_W-1:0]   slot_sel;
   desc_type           shown;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_ff;

   assign wr_desc.len        = req_ff.payload_length[LEN_W-1:0];
   assign wr_desc.gain       = req_ff.sensor_gain;
   assign wr_desc.infrared   = req_ff.infrared_on;
   assign wr_desc.frame_size = req_ff.frame_size_code;
   assign wr_desc.quality    = req_ff.jpeg_quality;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      drops_in  = drops_ff;
      drains_in = drains_ff;
      wr_en     = 1'b0;
      status    = ST_OK;
      slot_sel  = '0;
      shown     = '0;
      if (cmd.commit) begin
         case (req_ff.func)
            FUNC_ENQUEUE: begin
               if (!req_ff.payload_present || req_ff.payload_length == '0) begin
                  status = ST_INVALID;
               end else if (req_ff.payload_length > LEN_IN_W'(capacity)) begin
                  status = ST_TOO_LARGE;
               end else begin
                  slot_sel = head_ff;
                  bytes_in = bytes_ff + BYTES_W'(wr_desc.len);
                  if (count_ff == FULL_COUNT) begin
                     tail_in  = next_ptr(tail_ff);
                     drops_in = drops_ff + 1'b1;
                     bytes_in = bytes_ff + BYTES_W'(wr_desc.len) - BYTES_W'(rd_ff.len);
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
                  head_in = next_ptr(head_ff);
                  wr_en   = 1'b1;
               end
            end
            FUNC_PEEK, FUNC_RELEASE: begin
               if (count_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  slot_sel = tail_ff;
                  if (req_ff.func == FUNC_PEEK) begin
                     shown = rd_ff;
                  end else begin
                     bytes_in  = bytes_ff - BYTES_W'(rd_ff.len);
                     tail_in   = next_ptr(tail_ff);
                     count_in  = count_ff - 1'b1;
                     drains_in = drains_ff + 1'b1;
                  end
               end
            end
            default: begin
               status = ST_INVALID;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.status           = status;
         rsp_in.slot_index       = SLOT_OUT_W'(slot_sel);
         rsp_in.entry_length     = shown.len;
         rsp_in.entry_gain       = shown.gain;
         rsp_in.entry_infrared   = shown.infrared;
         rsp_in.entry_frame_size = shown.frame_size;
         rsp_in.entry_quality    = shown.quality;
         rsp_in.depth            = DEPTH_W'(count_in);
         rsp_in.bytes_held       = bytes_in;
         rsp_in.dropped_total    = drops_in;
         rsp_in.drained_total    = drains_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[head_ff] <= wr_desc;
      end
      if (cmd.load) begin
         rd_ff  <= store[tail_ff];
         req_ff <= req_word;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         drops_ff     <= '0;
         drains_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         drops_ff     <= drops_in;
         drains_ff    <= drains_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds the ring size");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> head_ff == tail_ff)
      else $error("head and tail disagree with the entry count");

   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> bytes_ff == '0)
      else $error("bytes held while the ring is empty");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented on the result channel");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the drop-oldest descriptor queue, predicting each result word.
`timescale 1ns / 1ps

module tb_top import dodq_pkg::*; ();

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dodq_chan_if #(.payload_type(req_word_type)) req_if ();
   dodq_chan_if #(.payload_type(rsp_word_type)) rsp_if ();

   drop_oldest_descriptor_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Predicted queue state.
   logic [LEN_W-1:0]   capacity_bytes;
   int                 head_slot;
   int                 tail_slot;
   int                 held_count;
   logic [BYTES_W-1:0] held_bytes;
   logic [TOTAL_W-1:0] drop_total;
   logic [TOTAL_W-1:0] drain_total;
   desc_type           slot_desc [SLOTS];

   rsp_word_type expected_results [$];
   int failure_count = 0;
   int cycle_count = 0;
   bit idling_on = 1'b0;
   int rsp_hold_cycles = 0;
   int rsp_stall_left = 0;

   function automatic void evict_oldest();
      held_bytes = held_bytes - BYTES_W'(slot_desc[tail_slot].len);
      slot_desc[tail_slot].len = '0;
      tail_slot = (tail_slot + 1) % SLOTS;
      held_count--;
   endfunction

   function automatic rsp_word_type predict_descriptor_result(req_word_type w);
      rsp_word_type r;
      int slot;
      r = '0;
      r.status = ST_OK;
      slot = 0;
      if (w.func == FUNC_ENQUEUE) begin
         if (!w.payload_present || w.payload_length == '0) begin
            r.status = ST_INVALID;
         end else if (w.payload_length > LEN_IN_W'(capacity_bytes)) begin
            r.status = ST_TOO_LARGE;
         end else begin
            if (held_count >= SLOTS) begin
               evict_oldest();
               drop_total = drop_total + 1'b1;
            end
            slot = head_slot;
            slot_desc[slot] = {w.payload_length[LEN_W-1:0], w.sensor_gain, w.infrared_on,
                               w.frame_size_code, w.jpeg_quality};
            head_slot = (head_slot + 1) % SLOTS;
            held_count++;
            held_bytes = held_bytes + BYTES_W'(w.payload_length[LEN_W-1:0]);
         end
      end else if (w.func == FUNC_PEEK || w.func == FUNC_RELEASE) begin
         if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            slot = tail_slot;
            if (w.func == FUNC_PEEK) begin
               {r.entry_length, r.entry_gain, r.entry_infrared, r.entry_frame_size,
                r.entry_quality} = slot_desc[slot];
            end else begin
               evict_oldest();
               drain_total = drain_total + 1'b1;
            end
         end
      end else begin
         r.status = ST_INVALID;
      end
      r.slot_index = SLOT_OUT_W'(slot);
      r.depth = DEPTH_W'(held_count);
      r.bytes_held = held_bytes;
      r.dropped_total = drop_total;
      r.drained_total = drain_total;
      return r;
   endfunction

   function automatic string mismatched_fields(rsp_word_type e, rsp_word_type a);
      string s;
      s = "";
      if (e.status != a.status) s = {s, " status"};
      if (e.slot_index != a.slot_index) s = {s, " slot_index"};
      if (e.entry_length != a.entry_length) s = {s, " entry_length"};
      if (e.entry_gain != a.entry_gain) s = {s, " entry_gain"};
      if (e.entry_infrared != a.entry_infrared) s = {s, " entry_infrared"};
      if (e.entry_frame_size != a.entry_frame_size) s = {s, " entry_frame_size"};
      if (e.entry_quality != a.entry_quality) s = {s, " entry_quality"};
      if (e.depth != a.depth) s = {s, " depth"};
      if (e.bytes_held != a.bytes_held) s = {s, " bytes_held"};
      if (e.dropped_total != a.dropped_total) s = {s, " dropped_total"};
      if (e.drained_total != a.drained_total) s = {s, " drained_total"};
      return s;
   endfunction

   function automatic void report_failure(string what);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) $display("tb_top: %s", what);
   endfunction

   function automatic req_word_type make_request(logic [FUNC_W-1:0] func, logic present,
                                                 logic [LEN_IN_W-1:0] len,
                                                 logic [GAIN_W-1:0] gain, logic infrared,
                                                 logic [FSIZE_W-1:0] fsize,
                                                 logic [QUAL_W-1:0] quality);
      req_word_type w;
      w.func = func;
      w.payload_present = present;
      w.payload_length = len;
      w.sensor_gain = gain;
      w.infrared_on = infrared;
      w.frame_size_code = fsize;
      w.jpeg_quality = quality;
      return w;
   endfunction

   function automatic logic [LEN_IN_W-1:0] random_length();
      case ($urandom_range(0, 9))
         0: return LEN_IN_W'(capacity_bytes);
         1: return LEN_IN_W'(capacity_bytes) + 1'b1;
         2: return '0;
         3: return LEN_IN_W'($urandom);
         4: return LEN_IN_W'(1);
         default: begin
            if (capacity_bytes == '0) return LEN_IN_W'($urandom);
            return LEN_IN_W'($urandom_range(1, capacity_bytes));
         end
      endcase
   endfunction

   function automatic req_word_type random_request(int enqueue_pct);
      req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < enqueue_pct) w.func = FUNC_ENQUEUE;
      else if (pick < 96) w.func = $urandom_range(0, 1) ? FUNC_PEEK : FUNC_RELEASE;
      else w.func = FUNC_UNUSED;
      w.payload_present = ($urandom_range(0, 15) != 0);
      w.payload_length = random_length();
      w.sensor_gain = GAIN_W'($urandom);
      w.infrared_on = 1'($urandom);
      w.frame_size_code = FSIZE_W'($urandom);
      w.jpeg_quality = QUAL_W'($urandom);
      return w;
   endfunction

   task automatic send_request(req_word_type w);
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.payload = w;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_descriptor_result(w));
   endtask

   task automatic sender_gap(int n);
      @(negedge clock);
      req_if.valid = 1'b0;
      repeat (n - 1) @(posedge clock);
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [LEN_W-1:0] value);
      wait_until_idle();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'(4 * CSR_IDX_CAPACITY);
      csr_pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      capacity_bytes = value;
   endtask

   task automatic test_directed_cases();
      send_request(make_request(FUNC_PEEK, 1'b1, 24'd10, 8'd1, 1'b0, 5'd1, 6'd1));
      send_request(make_request(FUNC_RELEASE, 1'b1, 24'd10, 8'd1, 1'b0, 5'd1, 6'd1));
      send_request(make_request(FUNC_ENQUEUE, 1'b0, 24'd100, 8'd7, 1'b1, 5'd3, 6'd9));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, 24'd0, 8'd7, 1'b1, 5'd3, 6'd9));
      send_request(make_request(FUNC_UNUSED, 1'b1, 24'd50, 8'd7, 1'b1, 5'd3, 6'd9));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, LEN_IN_W'(CAP_RESET) + 1'b1,
                                8'd2, 1'b0, 5'd4, 6'd5));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, 24'hFFFFFF, 8'd2, 1'b0, 5'd4, 6'd5));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, 24'd1, 8'd0, 1'b0, 5'd0, 6'd0));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, LEN_IN_W'(CAP_RESET),
                                8'hFF, 1'b1, 5'h1F, 6'h3F));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, 24'd1000, 8'hA5, 1'b0, 5'd10, 6'd20));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, 24'd2000, 8'h5A, 1'b1, 5'd21, 6'd42));
      send_request(make_request(FUNC_PEEK, 1'b0, 24'd0, 8'd0, 1'b0, 5'd0, 6'd0));
      send_request(make_request(FUNC_ENQUEUE, 1'b1, 24'd3000, 8'h33, 1'b1, 5'd17, 6'd33));
      send_request(make_request(FUNC_PEEK, 1'b1, 24'hFFFFFF, 8'hFF, 1'b1, 5'h1F, 6'h3F));
      send_request(make_request(FUNC_ENQUEUE, 1'b0, 24'd4000, 8'h44, 1'b0, 5'd2, 6'd2));
      repeat (4) begin
         send_request(make_request(FUNC_PEEK, 1'b1, 24'd5, 8'd3, 1'b0, 5'd6, 6'd7));
         send_request(make_request(FUNC_RELEASE, 1'b1, 24'd5, 8'd3, 1'b0, 5'd6, 6'd7));
      end
      send_request(make_request(FUNC_RELEASE, 1'b1, 24'd5, 8'd3, 1'b0, 5'd6, 6'd7));
      send_request(make_request(FUNC_PEEK, 1'b1, 24'd5, 8'd3, 1'b0, 5'd6, 6'd7));
   endtask

   task automatic test_random_traffic(logic [LEN_W-1:0] cap, int count, int enqueue_pct);
      set_capacity(cap);
      repeat (count) begin
         send_request(random_request(enqueue_pct));
         if (idling_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 4));
      end
   endtask

   task automatic test_output_backpressure();
      wait_until_idle();
      rsp_hold_cycles = 80;
      repeat (24) send_request(random_request(60));
   endtask

   task automatic test_unpaced_traffic();
      wait_until_idle();
      idling_on = 1'b0;
      test_random_traffic(CAP_RESET, 60, 50);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_stall_left > 0) begin
            rsp_if.ready = 1'b0;
            rsp_stall_left--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready = 1'b0;
            rsp_stall_left = $urandom_range(0, 3);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_word_type expected_word;
      string wrong;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_failure($sformatf("result word %h arrived with none expected",
                                     rsp_if.payload));
         end else begin
            expected_word = expected_results.pop_front();
            wrong = mismatched_fields(expected_word, rsp_if.payload);
            if (wrong != "") begin
               report_failure($sformatf("result word differs in%s: expected %h, got %h",
                                        wrong, expected_word, rsp_if.payload));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      capacity_bytes = CAP_RESET;
      head_slot = 0;
      tail_slot = 0;
      held_count = 0;
      held_bytes = '0;
      drop_total = '0;
      drain_total = '0;
      for (int i = 0; i < SLOTS; i++) slot_desc[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idling_on = 1'b1;

      test_directed_cases();
      test_random_traffic(CAP_RESET, 180, 50);
      test_random_traffic(LEN_W'(1), 70, 35);
      test_random_traffic(LEN_W'(0), 40, 40);
      test_random_traffic({LEN_W{1'b1}}, 130, 50);
      test_random_traffic(LEN_W'(1 << 20), 110, 30);
      test_random_traffic(LEN_W'($urandom_range(1, 1 << 20)), 110, 45);
      test_output_backpressure();
      test_unpaced_traffic();

      wait_until_idle();
      if (failure_count == 0 && expected_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/dodq_pkg.sv
hw/rtl/dodq_chan_if.sv
hw/rtl/dodq_csr.sv
hw/rtl/dodq_ctrl.sv
hw/rtl/dodq_datapath.sv
hw/rtl/drop_oldest_descriptor_queue.sv
tb/tb_top.sv
